@@ hw/rtl/lrp_pkg.sv @@
// shared constants, types and helper functions of the led ring pattern controller
package lrp_pkg;

	// ring sizes and derived frame geometry
	localparam int OUTER_COUNT  = 24;
	localparam int MIDDLE_COUNT = 16;
	localparam int INNER_COUNT  = 12;
	localparam int RING_NUM     = 3;
	localparam int FRAME_LEDS   = OUTER_COUNT + MIDDLE_COUNT + INNER_COUNT;
	localparam int PERIOD       = OUTER_COUNT * MIDDLE_COUNT * INNER_COUNT;
	localparam int TIME_STEP    = 36;

	localparam int MAX_COUNT = (OUTER_COUNT >= MIDDLE_COUNT) ?
		((OUTER_COUNT >= INNER_COUNT) ? OUTER_COUNT : INNER_COUNT) :
		((MIDDLE_COUNT >= INNER_COUNT) ? MIDDLE_COUNT : INNER_COUNT);
	localparam int MIN_COUNT = (OUTER_COUNT <= MIDDLE_COUNT) ?
		((OUTER_COUNT <= INNER_COUNT) ? OUTER_COUNT : INNER_COUNT) :
		((MIDDLE_COUNT <= INNER_COUNT) ? MIDDLE_COUNT : INNER_COUNT);

	// frame time ticks per ring step (product of the other two counts)
	localparam int OTHERS_OUTER  = PERIOD / OUTER_COUNT;
	localparam int OTHERS_MIDDLE = PERIOD / MIDDLE_COUNT;
	localparam int OTHERS_INNER  = PERIOD / INNER_COUNT;
	localparam int MAX_OTHERS    = PERIOD / MIN_COUNT;

	// widths
	localparam int POS_W   = $clog2(MAX_COUNT);
	localparam int LEN_W   = POS_W + 1;
	localparam int REM_W   = $clog2(MAX_OTHERS);
	localparam int FT_W    = $clog2(PERIOD);
	localparam int SUM_W   = $clog2(PERIOD + TIME_STEP + 1);
	localparam int STEP_W  = $clog2(TIME_STEP + 1);
	localparam int IDX_W   = 6;
	localparam int COLOR_W = 8;
	localparam int KIND_W  = 3;
	localparam int CMD_W   = 8;

	// request queue, depth a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// command byte codes
	localparam logic [CMD_W-1:0] CMD_OFF    = 8'h00;
	localparam logic [CMD_W-1:0] CMD_BLINK  = 8'h01;
	localparam logic [CMD_W-1:0] CMD_ROTATE = 8'h02;
	localparam logic [CMD_W-1:0] CMD_RING1  = 8'h11;
	localparam logic [CMD_W-1:0] CMD_RING2  = 8'h12;
	localparam logic [CMD_W-1:0] CMD_RING3  = 8'h13;
	localparam logic [CMD_W-1:0] CMD_SHOW   = 8'h21;

	// component select codes of a component write
	localparam logic [COLOR_W-1:0] SEL_RED   = 8'd1;
	localparam logic [COLOR_W-1:0] SEL_GREEN = 8'd2;
	localparam logic [COLOR_W-1:0] SEL_BLUE  = 8'd3;

	localparam logic [COLOR_W-1:0] FULL_ON = 8'hFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_CMD     = 3'd0,
		KIND_COMP    = 3'd1,
		KIND_RB_SEL  = 3'd2,
		KIND_RB_READ = 3'd3,
		KIND_FRAME   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_BLINK  = 2'd1,
		MODE_ROTATE = 2'd2,
		MODE_SHOW   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RING_OUTER  = 2'd0,
		RING_MIDDLE = 2'd1,
		RING_INNER  = 2'd2,
		RING_NONE   = 2'd3
	} ring_t;

	typedef enum logic [1:0] {
		COMP_RED   = 2'd0,
		COMP_GREEN = 2'd1,
		COMP_BLUE  = 2'd2
	} comp_t;

	typedef enum logic [2:0] {
		OP_MODE    = 3'd0,
		OP_COLOR   = 3'd1,
		OP_COMP    = 3'd2,
		OP_RB_SEL  = 3'd3,
		OP_RB_READ = 3'd4,
		OP_FRAME   = 3'd5
	} op_kind_t;

	typedef enum logic {
		BK_IDLE   = 1'b0,
		BK_PIXELS = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	// decoded request; a component write carries its value in rgb.red
	typedef struct packed {
		op_kind_t op;
		mode_t    mode;
		ring_t    ring;
		comp_t    comp;
		rgb_t     rgb;
	} op_t;

	typedef struct packed {
		logic push;
		op_t  op;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// ring named by a command byte
	function automatic ring_t ring_of(input logic [CMD_W-1:0] cmd);
		ring_t r;
		case (cmd)
			CMD_RING1: r = RING_OUTER;
			CMD_RING2: r = RING_MIDDLE;
			CMD_RING3: r = RING_INNER;
			default:   r = RING_NONE;
		endcase
		return r;
	endfunction

	// LED count of a ring
	function automatic logic [LEN_W-1:0] ring_len(input ring_t ring);
		logic [LEN_W-1:0] n;
		case (ring)
			RING_OUTER:  n = LEN_W'(OUTER_COUNT);
			RING_MIDDLE: n = LEN_W'(MIDDLE_COUNT);
			RING_INNER:  n = LEN_W'(INNER_COUNT);
			default:     n = LEN_W'(INNER_COUNT);
		endcase
		return n;
	endfunction

	// frame time ticks per window step of a ring
	function automatic logic [REM_W:0] ring_others(input ring_t ring);
		logic [REM_W:0] o;
		case (ring)
			RING_OUTER:  o = (REM_W+1)'(OTHERS_OUTER);
			RING_MIDDLE: o = (REM_W+1)'(OTHERS_MIDDLE);
			RING_INNER:  o = (REM_W+1)'(OTHERS_INNER);
			default:     o = (REM_W+1)'(OTHERS_INNER);
		endcase
		return o;
	endfunction

endpackage

@@ hw/rtl/lrp_intf.sv @@
// request and response channel interfaces of the led ring pattern controller
interface lrp_req_if;
	logic                          valid;
	logic                          ready;
	logic [lrp_pkg::KIND_W-1:0]    kind;
	logic [lrp_pkg::CMD_W-1:0]     command;
	logic [lrp_pkg::COLOR_W-1:0]   byte_a;
	logic [lrp_pkg::COLOR_W-1:0]   byte_b;
	logic [lrp_pkg::COLOR_W-1:0]   byte_c;

	modport source (output valid, kind, command, byte_a, byte_b, byte_c, input ready);
	modport sink (input valid, kind, command, byte_a, byte_b, byte_c, output ready);
endinterface

interface lrp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lrp_pkg::IDX_W-1:0]     led_index;
	logic [lrp_pkg::COLOR_W-1:0]   red;
	logic [lrp_pkg::COLOR_W-1:0]   green;
	logic [lrp_pkg::COLOR_W-1:0]   blue;
	logic                          is_readback;
	logic                          last;

	modport source (output valid, led_index, red, green, blue, is_readback, last,
		input ready);
	modport sink (input valid, led_index, red, green, blue, is_readback, last,
		output ready);
endinterface

@@ hw/rtl/lrp_front.sv @@
// front end: accepts requests and decodes them into queue operations
module lrp_front (
	lrp_req_if.sink             req,
	input  lrp_pkg::q_status_t  qs,
	output lrp_pkg::push_t      push
);

	lrp_pkg::ring_t ring;
	logic           accept;

	assign req.ready = !qs.full;
	assign accept    = req.valid && !qs.full;
	assign ring      = lrp_pkg::ring_of(req.command);

	// classify the request; ignored requests are dropped here
	always_comb begin
		push.push          = 1'b0;
		push.op.op         = lrp_pkg::OP_MODE;
		push.op.mode       = lrp_pkg::MODE_OFF;
		push.op.ring       = ring;
		push.op.comp       = lrp_pkg::COMP_RED;
		push.op.rgb.red    = req.byte_a;
		push.op.rgb.green  = req.byte_b;
		push.op.rgb.blue   = req.byte_c;
		case (lrp_pkg::kind_t'(req.kind))
			lrp_pkg::KIND_CMD: begin
				case (req.command)
					lrp_pkg::CMD_OFF: begin
						push.push    = accept;
						push.op.mode = lrp_pkg::MODE_OFF;
					end
					lrp_pkg::CMD_BLINK: begin
						push.push    = accept;
						push.op.mode = lrp_pkg::MODE_BLINK;
					end
					lrp_pkg::CMD_ROTATE: begin
						push.push    = accept;
						push.op.mode = lrp_pkg::MODE_ROTATE;
					end
					lrp_pkg::CMD_SHOW: begin
						push.push    = accept;
						push.op.mode = lrp_pkg::MODE_SHOW;
					end
					default: begin
						push.push  = accept && (ring != lrp_pkg::RING_NONE);
						push.op.op = lrp_pkg::OP_COLOR;
					end
				endcase
			end
			lrp_pkg::KIND_COMP: begin
				push.op.op      = lrp_pkg::OP_COMP;
				push.op.rgb.red = req.byte_b;
				case (req.byte_a)
					lrp_pkg::SEL_RED: begin
						push.push    = accept && (ring != lrp_pkg::RING_NONE);
						push.op.comp = lrp_pkg::COMP_RED;
					end
					lrp_pkg::SEL_GREEN: begin
						push.push    = accept && (ring != lrp_pkg::RING_NONE);
						push.op.comp = lrp_pkg::COMP_GREEN;
					end
					lrp_pkg::SEL_BLUE: begin
						push.push    = accept && (ring != lrp_pkg::RING_NONE);
						push.op.comp = lrp_pkg::COMP_BLUE;
					end
					default: push.push = 1'b0;
				endcase
			end
			lrp_pkg::KIND_RB_SEL: begin
				push.push  = accept && (ring != lrp_pkg::RING_NONE);
				push.op.op = lrp_pkg::OP_RB_SEL;
			end
			lrp_pkg::KIND_RB_READ: begin
				push.push  = accept;
				push.op.op = lrp_pkg::OP_RB_READ;
			end
			lrp_pkg::KIND_FRAME: begin
				push.push  = accept;
				push.op.op = lrp_pkg::OP_FRAME;
			end
			default: push.push = 1'b0;
		endcase
	end

endmodule

@@ hw/rtl/lrp_fifo.sv @@
// short operation queue between the front end and the back end
module lrp_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  lrp_pkg::push_t     push,
	input  logic               pop,
	output lrp_pkg::op_t       head,
	output lrp_pkg::q_status_t qs
);

	lrp_pkg::op_t                mem_q [lrp_pkg::QUEUE_DEPTH];
	logic [lrp_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [lrp_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [lrp_pkg::QPTR_W:0]    count_q;

	assign qs.full  = (count_q == (lrp_pkg::QPTR_W+1)'(lrp_pkg::QUEUE_DEPTH));
	assign qs.empty = (count_q == '0);
	assign head     = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.push && qs.full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qs.empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (lrp_pkg::QPTR_W+1)'(lrp_pkg::QUEUE_DEPTH))
		else $error("queue fill count out of range");

endmodule

@@ hw/rtl/lrp_back.sv @@
// back end: holds display state, executes operations and scans frames
module lrp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lrp_pkg::op_t       head,
	input  lrp_pkg::q_status_t qs,
	output logic               pop,
	lrp_rsp_if.source          rsp
);

	// display state
	lrp_pkg::mode_t              mode_q;
	lrp_pkg::rgb_t               color_q [lrp_pkg::RING_NUM];
	lrp_pkg::ring_t              rb_ring_q;
	logic [lrp_pkg::FT_W-1:0]    ft_q;
	logic [lrp_pkg::REM_W-1:0]   rem_q [lrp_pkg::RING_NUM];
	logic [lrp_pkg::POS_W-1:0]   start_q [lrp_pkg::RING_NUM];
	logic [lrp_pkg::STEP_W-1:0]  step_q;

	// frame scan state
	lrp_pkg::back_state_t        state_q, state_d;
	lrp_pkg::ring_t              pix_ring_q;
	logic [lrp_pkg::POS_W-1:0]   pos_q;
	logic [lrp_pkg::POS_W-1:0]   off_q;
	logic [lrp_pkg::IDX_W-1:0]   idx_q;
	logic [lrp_pkg::POS_W-1:0]   snap_start_q [lrp_pkg::RING_NUM];
	logic                        blink_q;

	// output register
	logic                        out_valid_q;
	logic [lrp_pkg::IDX_W-1:0]   out_idx_q;
	lrp_pkg::rgb_t               out_rgb_q;
	logic                        out_rb_q;
	logic                        out_last_q;

	logic                        out_free;
	logic                        emit_pix;
	logic                        emit_rb;
	logic                        pop_frame;
	logic                        wrap;
	logic [lrp_pkg::LEN_W-1:0]   pix_len;
	logic                        pix_end;
	logic                        pix_last;
	logic                        lit;
	lrp_pkg::rgb_t               pix_rgb;
	lrp_pkg::ring_t              next_ring;
	logic [lrp_pkg::POS_W-1:0]   next_off;
	logic [lrp_pkg::POS_W-1:0]   first_off;

	// offset of the first LED of a ring from the window start
	function automatic logic [lrp_pkg::POS_W-1:0] init_off(
		input logic [lrp_pkg::POS_W-1:0] start,
		input logic [lrp_pkg::LEN_W-1:0] len
	);
		logic [lrp_pkg::LEN_W-1:0] diff;
		diff = len - {1'b0, start};
		return (start == '0) ? '0 : diff[lrp_pkg::POS_W-1:0];
	endfunction

	assign out_free = !out_valid_q || rsp.ready;
	assign pop = (state_q == lrp_pkg::BK_IDLE) && (step_q == '0) && !qs.empty && out_free;
	assign pop_frame = pop && (head.op == lrp_pkg::OP_FRAME);
	assign wrap = (lrp_pkg::SUM_W'(ft_q)
		+ lrp_pkg::SUM_W'(lrp_pkg::TIME_STEP)) >= lrp_pkg::SUM_W'(lrp_pkg::PERIOD);

	// next state of the frame scan
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrp_pkg::BK_IDLE: begin
				if (pop_frame) begin
					state_d = lrp_pkg::BK_PIXELS;
				end
			end
			lrp_pkg::BK_PIXELS: begin
				if (out_free && pix_last) begin
					state_d = lrp_pkg::BK_IDLE;
				end
			end
			default: state_d = lrp_pkg::BK_IDLE;
		endcase
	end

	// scan outputs: current pixel color and where the scan goes next
	always_comb begin
		pix_len   = lrp_pkg::ring_len(pix_ring_q);
		pix_end   = ({1'b0, pos_q} == (pix_len - 1'b1));
		pix_last  = pix_end && (pix_ring_q == lrp_pkg::RING_INNER);
		lit       = {1'b0, off_q} < (pix_len >> 1);
		next_ring = lrp_pkg::ring_t'(pix_ring_q + 1'b1);
		next_off  = ({1'b0, off_q} + 1'b1 == pix_len) ? '0 : off_q + 1'b1;
		first_off = init_off(snap_start_q[next_ring], lrp_pkg::ring_len(next_ring));
		emit_pix  = (state_q == lrp_pkg::BK_PIXELS) && out_free;
		emit_rb   = pop && (head.op == lrp_pkg::OP_RB_READ);
		pix_rgb   = '0;
		case (mode_q)
			lrp_pkg::MODE_OFF:    pix_rgb = '0;
			lrp_pkg::MODE_BLINK:  pix_rgb.blue = blink_q ? lrp_pkg::FULL_ON : '0;
			lrp_pkg::MODE_ROTATE: pix_rgb.blue = lit ? lrp_pkg::FULL_ON : '0;
			lrp_pkg::MODE_SHOW:   pix_rgb = color_q[pix_ring_q];
			default:              pix_rgb = '0;
		endcase
	end

	// scan counters and snapshot of the window starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lrp_pkg::BK_IDLE;
			pix_ring_q <= lrp_pkg::RING_OUTER;
			pos_q      <= '0;
			off_q      <= '0;
			idx_q      <= '0;
			blink_q    <= 1'b0;
			for (int k = 0; k < lrp_pkg::RING_NUM; k++) begin
				snap_start_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop_frame) begin
				pix_ring_q <= lrp_pkg::RING_OUTER;
				pos_q      <= '0;
				idx_q      <= '0;
				off_q      <= init_off(start_q[lrp_pkg::RING_OUTER],
					lrp_pkg::ring_len(lrp_pkg::RING_OUTER));
				blink_q    <= ft_q > lrp_pkg::FT_W'(lrp_pkg::PERIOD / 2);
				for (int k = 0; k < lrp_pkg::RING_NUM; k++) begin
					snap_start_q[k] <= start_q[k];
				end
			end else if (emit_pix) begin
				idx_q <= idx_q + 1'b1;
				if (pix_end) begin
					pix_ring_q <= next_ring;
					pos_q      <= '0;
					off_q      <= first_off;
				end else begin
					pos_q <= pos_q + 1'b1;
					off_q <= next_off;
				end
			end
		end
	end

	// operation execution and frame timer advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lrp_pkg::MODE_OFF;
			rb_ring_q <= lrp_pkg::RING_OUTER;
			ft_q      <= '0;
			step_q    <= '0;
			for (int k = 0; k < lrp_pkg::RING_NUM; k++) begin
				color_q[k] <= '0;
				rem_q[k]   <= '0;
				start_q[k] <= '0;
			end
		end else begin
			if (pop) begin
				case (head.op)
					lrp_pkg::OP_MODE:   mode_q <= head.mode;
					lrp_pkg::OP_COLOR:  color_q[head.ring] <= head.rgb;
					lrp_pkg::OP_COMP: begin
						case (head.comp)
							lrp_pkg::COMP_RED:   color_q[head.ring].red   <= head.rgb.red;
							lrp_pkg::COMP_GREEN: color_q[head.ring].green <= head.rgb.red;
							lrp_pkg::COMP_BLUE:  color_q[head.ring].blue  <= head.rgb.red;
							default:             color_q[head.ring].red   <= head.rgb.red;
						endcase
					end
					lrp_pkg::OP_RB_SEL: rb_ring_q <= head.ring;
					lrp_pkg::OP_FRAME: begin
						if (wrap) begin
							ft_q   <= '0;
							step_q <= '0;
							for (int k = 0; k < lrp_pkg::RING_NUM; k++) begin
								rem_q[k]   <= '0;
								start_q[k] <= '0;
							end
						end else begin
							step_q <= lrp_pkg::STEP_W'(lrp_pkg::TIME_STEP);
						end
					end
					default: ;
				endcase
			end else if (step_q != '0) begin
				// one tick of the timer per cycle, window starts follow
				ft_q   <= ft_q + 1'b1;
				step_q <= step_q - 1'b1;
				for (int k = 0; k < lrp_pkg::RING_NUM; k++) begin
					if ({1'b0, rem_q[k]} + 1'b1 == lrp_pkg::ring_others(lrp_pkg::ring_t'(k))) begin
						rem_q[k]   <= '0;
						start_q[k] <= start_q[k] + 1'b1;
					end else begin
						rem_q[k] <= rem_q[k] + 1'b1;
					end
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_rb || emit_pix) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_rb) begin
			out_idx_q  <= '0;
			out_rgb_q  <= color_q[rb_ring_q];
			out_rb_q   <= 1'b1;
			out_last_q <= 1'b1;
		end else if (emit_pix) begin
			out_idx_q  <= idx_q;
			out_rgb_q  <= pix_rgb;
			out_rb_q   <= 1'b0;
			out_last_q <= pix_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.led_index   = out_idx_q;
	assign rsp.red         = out_rgb_q.red;
	assign rsp.green       = out_rgb_q.green;
	assign rsp.blue        = out_rgb_q.blue;
	assign rsp.is_readback = out_rb_q;
	assign rsp.last        = out_last_q;

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		ft_q < lrp_pkg::FT_W'(lrp_pkg::PERIOD))
		else $error("frame time beyond period");
	a_scan_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrp_pkg::BK_PIXELS) |-> (pix_ring_q != lrp_pkg::RING_NONE))
		else $error("frame scan past the inner ring");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_pix && pix_last) |=> (state_q == lrp_pkg::BK_IDLE))
		else $error("frame scan did not stop after its last pixel");
	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (out_free && step_q == '0))
		else $error("operation taken while back end busy");

endmodule

@@ hw/rtl/led_ring_pattern_controller_top.sv @@
// top level of the led ring pattern controller
// Requests enter a decoder that drops unknown kinds, commands, rings and components, then a
// four-entry queue, then the back end that holds mode, ring colors, readback select and the
// frame timer. Mode, color and select requests give no response; a readback read gives one
// response. A frame tick streams all 52 LED colors, one per cycle while the receiver is
// ready, outer ring first, with last on the final one; the pixel scan counter sets this
// figure. Unless it wraps to zero, the timer advances by 36 ticks, one tick per cycle
// alongside the scan, and the back end takes no new operation until both the scan and the
// timer advance are done. The decoder keeps taking requests while the queue has room, also
// while a response waits in the output register.
module led_ring_pattern_controller_top (
	input  logic      clk,
	input  logic      arst_n,
	lrp_req_if.sink   req,
	lrp_rsp_if.source rsp
);

	lrp_pkg::push_t     push;
	lrp_pkg::q_status_t qs;
	lrp_pkg::op_t       head;
	logic               pop;

	// decode
	lrp_front u_front (
		.req  (req),
		.qs   (qs),
		.push (push)
	);

	// queue
	lrp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qs     (qs)
	);

	// execute
	lrp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qs     (qs),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

@@ bench/testbench.sv @@
// testbench of the led ring pattern controller: random requests, predicted pixels and readbacks
`timescale 1ns / 1ps

module testbench;
	import lrp_pkg::*;

	localparam int RANDOM_ITEMS   = 212;
	localparam int PHASE_COUNT    = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;
	localparam int MAX_PRINTS     = 100;

	// per phase: sender idle and receiver stall, percent of cycles
	localparam int SEND_IDLE [PHASE_COUNT] = '{0, 59, 0, 16};
	localparam int RSP_STALL [PHASE_COUNT] = '{0, 0, 59, 16};

	// request codes that the block must drop
	localparam logic [KIND_W-1:0]  KIND_FIRST_UNUSED = 3'd5;
	localparam logic [KIND_W-1:0]  KIND_LAST_UNUSED  = 3'd7;
	localparam logic [CMD_W-1:0]   CMD_UNLISTED      = 8'hFF;
	localparam logic [CMD_W-1:0]   CMD_NEAR_RING     = 8'h10;
	localparam logic [COLOR_W-1:0] SEL_NONE          = 8'd0;
	localparam logic [COLOR_W-1:0] SEL_UNLISTED      = 8'hFF;

	typedef struct packed {
		logic [IDX_W-1:0] led_index;
		rgb_t             color;
		logic             is_readback;
		logic             last;
	} led_result_t;

	// tracks ring state and the pixels and readbacks still owed by the block
	class ring_frame_scoreboard;
		led_result_t owed_q[$];
		int          mismatches;
		mode_t       mode;
		rgb_t        ring_rgb [RING_NUM];
		ring_t       readback_sel;
		int unsigned frame_time;
		int unsigned ring_size [RING_NUM];

		function new();
			mismatches   = 0;
			mode         = MODE_OFF;
			readback_sel = RING_OUTER;
			frame_time   = 0;
			foreach (ring_rgb[i]) ring_rgb[i] = '0;
			ring_size[0] = OUTER_COUNT;
			ring_size[1] = MIDDLE_COUNT;
			ring_size[2] = INNER_COUNT;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		task report(input string msg);
			if (mismatches < MAX_PRINTS)
				$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// one frame: every led of every ring, then the timer step
		function void predict_frame();
			led_result_t px;
			int unsigned base, n, others, start, offset;
			base = 0;
			for (int ri = 0; ri < RING_NUM; ri++) begin
				n      = ring_size[ri];
				others = PERIOD / n;
				start  = (frame_time / others) % n;
				for (int unsigned i = 0; i < n; i++) begin
					px.led_index   = IDX_W'(base + i);
					px.color       = '0;
					px.is_readback = 1'b0;
					px.last        = (base + i + 1 == FRAME_LEDS);
					case (mode)
						MODE_BLINK: begin
							if (frame_time > PERIOD / 2) px.color.blue = FULL_ON;
						end
						MODE_ROTATE: begin
							offset = (i + n - start) % n;
							if (offset < n / 2) px.color.blue = FULL_ON;
						end
						MODE_SHOW: begin
							px.color = ring_rgb[ri];
						end
						default: ;
					endcase
					owed_q.push_back(px);
				end
				base += n;
			end
			if (frame_time + TIME_STEP >= PERIOD) frame_time = 0;
			else frame_time += TIME_STEP;
		endfunction

		// accepted request; returns 0 when the block drops it
		function bit note_request(input logic [KIND_W-1:0] kind,
			input logic [CMD_W-1:0] cmd, input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] c);
			ring_t       ring;
			led_result_t rb;
			bit          took;
			case (cmd)
				CMD_RING1: ring = RING_OUTER;
				CMD_RING2: ring = RING_MIDDLE;
				CMD_RING3: ring = RING_INNER;
				default:   ring = RING_NONE;
			endcase
			took = 1'b0;
			case (kind)
				KIND_CMD: begin
					took = 1'b1;
					case (cmd)
						CMD_OFF:    mode = MODE_OFF;
						CMD_BLINK:  mode = MODE_BLINK;
						CMD_ROTATE: mode = MODE_ROTATE;
						CMD_SHOW:   mode = MODE_SHOW;
						default: begin
							if (ring != RING_NONE) ring_rgb[ring] = {a, b, c};
							else took = 1'b0;
						end
					endcase
				end
				KIND_COMP: begin
					if (ring != RING_NONE && a >= SEL_RED && a <= SEL_BLUE) begin
						took = 1'b1;
						case (a)
							SEL_RED:   ring_rgb[ring].red = b;
							SEL_GREEN: ring_rgb[ring].green = b;
							default:   ring_rgb[ring].blue = b;
						endcase
					end
				end
				KIND_RB_SEL: begin
					if (ring != RING_NONE) begin
						took = 1'b1;
						readback_sel = ring;
					end
				end
				KIND_RB_READ: begin
					took           = 1'b1;
					rb.led_index   = '0;
					rb.color       = ring_rgb[readback_sel];
					rb.is_readback = 1'b1;
					rb.last        = 1'b1;
					owed_q.push_back(rb);
				end
				KIND_FRAME: begin
					took = 1'b1;
					predict_frame();
				end
				default: ;
			endcase
			return took;
		endfunction

		// compare a result with the oldest owed one
		task check_result(input led_result_t got);
			led_result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("result led %0d with nothing owed", got.led_index));
				return;
			end
			want = owed_q.pop_front();
			if (got.led_index !== want.led_index)
				report($sformatf("led_index %0d, want %0d", got.led_index, want.led_index));
			if (got.color.red !== want.color.red)
				report($sformatf("led %0d red %h, want %h", want.led_index,
					got.color.red, want.color.red));
			if (got.color.green !== want.color.green)
				report($sformatf("led %0d green %h, want %h", want.led_index,
					got.color.green, want.color.green));
			if (got.color.blue !== want.color.blue)
				report($sformatf("led %0d blue %h, want %h", want.led_index,
					got.color.blue, want.color.blue));
			if (got.is_readback !== want.is_readback)
				report($sformatf("led %0d is_readback %b, want %b", want.led_index,
					got.is_readback, want.is_readback));
			if (got.last !== want.last)
				report($sformatf("led %0d last %b, want %b", want.led_index,
					got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   rsp_stall_pct;
	bit   request_took_effect;

	ring_frame_scoreboard sb = new();

	lrp_req_if req ();
	lrp_rsp_if rsp ();

	led_ring_pattern_controller_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result({rsp.led_index, rsp.red, rsp.green, rsp.blue,
				rsp.is_readback, rsp.last});
	end

	// watchdog on cycles with no request or result moving
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stuck = 0;
			else stuck++;
		end
		$display("led_ring_pattern_controller_top test failed");
		$finish;
	end

	// drive one request, with a random gap before it, until accepted
	task automatic send_request(input logic [KIND_W-1:0] kind,
		input logic [CMD_W-1:0] cmd, input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.kind    <= kind;
		req.command <= cmd;
		req.byte_a  <= a;
		req.byte_b  <= b;
		req.byte_c  <= c;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		request_took_effect = sb.note_request(kind, cmd, a, b, c);
	endtask

	// sender holds off until every owed result has come
	task automatic hold_until_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int unsigned           pick;
		logic [KIND_W-1:0]     kind;
		logic [CMD_W-1:0]      cmd;
		logic [COLOR_W-1:0]    a, b, c;
		int                    counted;

		arst_n        = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		req.valid     = 1'b0;
		req.kind      = '0;
		req.command   = '0;
		req.byte_a    = '0;
		req.byte_b    = '0;
		req.byte_c    = '0;
		rsp.ready     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset state, ring colors, components, readback, unknown codes, modes
		send_request(KIND_RB_READ, CMD_OFF, 8'h00, 8'h00, 8'h00);
		send_request(KIND_FRAME, CMD_UNLISTED, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_CMD, CMD_RING1, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_CMD, CMD_RING2, 8'h00, 8'h80, 8'h7F);
		send_request(KIND_CMD, CMD_RING3, 8'h5A, 8'hA5, 8'h01);
		send_request(KIND_CMD, CMD_UNLISTED, 8'h12, 8'h34, 8'h56);
		send_request(KIND_CMD, CMD_NEAR_RING, 8'h00, 8'h00, 8'h00);
		send_request(KIND_COMP, CMD_RING2, SEL_RED, 8'h3C, 8'hFF);
		send_request(KIND_COMP, CMD_RING3, SEL_GREEN, 8'hFF, 8'h00);
		send_request(KIND_COMP, CMD_RING1, SEL_BLUE, 8'h00, 8'h00);
		send_request(KIND_COMP, CMD_RING1, SEL_NONE, 8'h11, 8'h00);
		send_request(KIND_COMP, CMD_RING1, SEL_UNLISTED, 8'h22, 8'h00);
		send_request(KIND_COMP, CMD_SHOW, SEL_RED, 8'h33, 8'h00);
		send_request(KIND_RB_SEL, CMD_RING2, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_RB_READ, CMD_UNLISTED, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_RB_SEL, CMD_RING3, 8'h00, 8'h00, 8'h00);
		send_request(KIND_RB_SEL, CMD_OFF, 8'h00, 8'h00, 8'h00);
		send_request(KIND_RB_READ, CMD_OFF, 8'h00, 8'h00, 8'h00);
		send_request(KIND_FIRST_UNUSED, CMD_RING1, SEL_RED, 8'hAA, 8'h55);
		send_request(KIND_FIRST_UNUSED + 3'd1, CMD_RING2, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_LAST_UNUSED, CMD_SHOW, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, CMD_SHOW, 8'h00, 8'h00, 8'h00);
		send_request(KIND_FRAME, CMD_OFF, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, CMD_BLINK, 8'h00, 8'h00, 8'h00);
		send_request(KIND_FRAME, CMD_OFF, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, CMD_ROTATE, 8'h00, 8'h00, 8'h00);
		send_request(KIND_FRAME, CMD_OFF, 8'h00, 8'h00, 8'h00);
		hold_until_drained();

		// random requests, mostly well formed, over the sender idle and receiver stall phases
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			rsp_stall_pct = RSP_STALL[phase];
			counted = 0;
			while (counted < RANDOM_ITEMS / PHASE_COUNT) begin
				pick = $urandom_range(99);
				cmd  = CMD_W'($urandom_range(255));
				a    = COLOR_W'($urandom_range(255));
				b    = COLOR_W'($urandom_range(255));
				c    = COLOR_W'($urandom_range(255));
				if (pick < 55) begin
					kind = KIND_FRAME;
				end else if (pick < 70) begin
					kind = KIND_CMD;
					case ($urandom_range(9))
						0: cmd = CMD_OFF;
						1: cmd = CMD_BLINK;
						2, 3: cmd = CMD_ROTATE;
						4, 5: cmd = CMD_SHOW;
						6: cmd = CMD_RING1;
						7: cmd = CMD_RING2;
						8: cmd = CMD_RING3;
						default: ;
					endcase
				end else if (pick < 96) begin
					if (pick < 80) kind = KIND_COMP;
					else if (pick < 88) kind = KIND_RB_SEL;
					else kind = KIND_RB_READ;
					case ($urandom_range(7))
						0, 1: cmd = CMD_RING1;
						2, 3: cmd = CMD_RING2;
						4, 5, 6: cmd = CMD_RING3;
						default: ;
					endcase
					if ($urandom_range(7) != 0) a = COLOR_W'($urandom_range(SEL_RED, SEL_BLUE));
				end else begin
					kind = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
				end
				send_request(kind, cmd, a, b, c);
				if (request_took_effect) counted++;
			end
			hold_until_drained();
		end

		// wind down
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("led_ring_pattern_controller_top test passed");
		else
			$display("led_ring_pattern_controller_top test failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lrp_pkg.sv
hw/rtl/lrp_intf.sv
hw/rtl/lrp_front.sv
hw/rtl/lrp_fifo.sv
hw/rtl/lrp_back.sv
hw/rtl/led_ring_pattern_controller_top.sv
bench/testbench.sv
